FILE: rtl/ccpp_pkg.sv
// ----------------------------------------------------------------------------
// ccpp_pkg
// Shared types, tag codes and field layout for the constant pool parser.
// ----------------------------------------------------------------------------
package ccpp_pkg;

   // constant pool tag codes
   localparam logic [7:0] TAG_UTF8         = 8'd1;
   localparam logic [7:0] TAG_INTEGER      = 8'd3;
   localparam logic [7:0] TAG_FLOAT        = 8'd4;
   localparam logic [7:0] TAG_LONG         = 8'd5;
   localparam logic [7:0] TAG_DOUBLE       = 8'd6;
   localparam logic [7:0] TAG_CLASS        = 8'd7;
   localparam logic [7:0] TAG_STRING       = 8'd8;
   localparam logic [7:0] TAG_FIELDREF     = 8'd9;
   localparam logic [7:0] TAG_METHODREF    = 8'd10;
   localparam logic [7:0] TAG_IMETHODREF   = 8'd11;
   localparam logic [7:0] TAG_NAME_TYPE    = 8'd12;
   localparam logic [7:0] TAG_METHOD_HNDL  = 8'd15;
   localparam logic [7:0] TAG_METHOD_TYPE  = 8'd16;
   localparam logic [7:0] TAG_INVOKE_DYN   = 8'd18;

   // input transaction kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_FIELDS = 3'd1,
      PH_TEXT   = 3'd2
   } parse_phase_type;

   typedef struct packed {
      logic       known;
      logic [2:0] f1_len;
      logic [2:0] f2_len;
   } tag_layout_type;

   // one result transaction
   typedef struct packed {
      logic [15:0] slot_index;
      logic [7:0]  entry_tag;
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic [7:0]  text_byte;
      logic        is_text_byte;
      logic        entry_done;
      logic        bad_tag;
      logic        pool_done;
   } rsp_rec_type;

   // byte counts of the first and second field of a tag
   function automatic tag_layout_type tag_layout(input logic [7:0] tag);
      tag_layout_type lay;
      lay = '0;
      unique case (tag) inside
         TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: begin
            lay = '{known: 1'b1, f1_len: 3'd2, f2_len: 3'd0};
         end
         TAG_INTEGER, TAG_FLOAT: begin
            lay = '{known: 1'b1, f1_len: 3'd4, f2_len: 3'd0};
         end
         TAG_LONG, TAG_DOUBLE: begin
            lay = '{known: 1'b1, f1_len: 3'd4, f2_len: 3'd4};
         end
         TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAME_TYPE,
         TAG_INVOKE_DYN: begin
            lay = '{known: 1'b1, f1_len: 3'd2, f2_len: 3'd2};
         end
         TAG_METHOD_HNDL: begin
            lay = '{known: 1'b1, f1_len: 3'd1, f2_len: 3'd2};
         end
         default: begin
            lay = '0;
         end
      endcase
      return lay;
   endfunction

endpackage

FILE: rtl/ccpp_rsp_queue.sv
// ----------------------------------------------------------------------------
// ccpp_rsp_queue
// Four-entry shifting result queue; takes up to two records per cycle.
// ----------------------------------------------------------------------------
module ccpp_rsp_queue
   import ccpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  push_cnt,
   input  rsp_rec_type push_rec [2],
   output logic        has_room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_rec_type rsp_rec
);

   rsp_rec_type entry_ff [4];
   rsp_rec_type entry_in [4];
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic        pop;
   logic [2:0]  base;

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_rec   = entry_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign has_room  = (count_ff <= 3'd2);
   assign base      = count_ff - {2'b00, pop};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (pop && i < 3) begin
            entry_in[i] = entry_ff[(i + 1) % 4];
         end else begin
            entry_in[i] = entry_ff[i];
         end
         if (push_cnt != 2'd0 && base == 3'(i)) begin
            entry_in[i] = push_rec[0];
         end
         if (push_cnt == 2'd2 && base + 3'd1 == 3'(i)) begin
            entry_in[i] = push_rec[1];
         end
      end
      count_in = base + {1'b0, push_cnt};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: rtl/class_constant_pool_parser.sv
// ----------------------------------------------------------------------------
// class_constant_pool_parser
// Streaming parser for a class file constant pool, one byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock: a raw pool byte
// (big-endian stream) or a restart. Each byte updates the parse state in the
// cycle it is taken and gives zero, one or two result transactions: a record
// per finished entry (two for Long/Double), one per Utf8 text byte, and one
// error record on an unknown tag, after which bytes are dropped until a
// restart. Results land in a four-entry queue in front of the rsp channel;
// req_stall rises only while fewer than two places are free there, so with
// the output draining the parser sustains one byte per clock. Write
// pool_count (byte address 0) only while the block is idle; parsing stops
// once pool_count - 1 slots are filled.
// ----------------------------------------------------------------------------
module class_constant_pool_parser
   import ccpp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_pool_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_slot_index,
   output logic [7:0]  rsp_entry_tag,
   output logic [31:0] rsp_first_value,
   output logic [31:0] rsp_second_value,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_is_text_byte,
   output logic        rsp_entry_done,
   output logic        rsp_bad_tag,
   output logic        rsp_pool_done,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [1:0] ADDR_POOL_COUNT = 2'd0;

   // parse state
   parse_phase_type phase_ff,   phase_in;
   logic [7:0]      tag_ff,     tag_in;
   logic [3:0]      fbc_ff,     fbc_in;
   logic [15:0]     text_ff,    text_in;
   logic [31:0]     acc1_ff,    acc1_in;
   logic [31:0]     acc2_ff,    acc2_in;
   logic [15:0]     slots_ff,   slots_in;
   logic            halted_ff,  halted_in;
   logic [15:0]     pool_count_ff;

   logic            req_accept;
   logic            has_room;
   logic [1:0]      push_cnt;
   rsp_rec_type     push_rec [2];
   rsp_rec_type     head_rec;

   // parse step scratch
   tag_layout_type  lay;
   logic            more_slots;
   logic            finish;
   logic            text_first;
   logic            wide;
   logic            pdone;
   rsp_rec_type     rec_a;
   rsp_rec_type     rec_b;

   //---------------------------------------------------------------------
   // register port: pready tied high, one register
   //---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_POOL_COUNT) ? {16'd0, pool_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_count_ff <= 16'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == ADDR_POOL_COUNT) begin
         pool_count_ff <= csr_pwdata[15:0];
      end
   end

   //---------------------------------------------------------------------
   // parse step: one byte per accepted transaction
   //---------------------------------------------------------------------
   assign req_stall  = !has_room;
   assign req_accept = req_valid && !req_stall;

   // room for another slot: slots_filled + 1 < pool_count
   assign more_slots = ({1'b0, slots_ff} + 17'd1) < {1'b0, pool_count_ff};

   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      fbc_in     = fbc_ff;
      text_in    = text_ff;
      acc1_in    = acc1_ff;
      acc2_in    = acc2_ff;
      slots_in   = slots_ff;
      halted_in  = halted_ff;
      push_cnt   = 2'd0;
      push_rec[0] = '0;
      push_rec[1] = '0;
      finish     = 1'b0;
      text_first = 1'b0;
      lay        = tag_layout(tag_ff);
      wide       = 1'b0;
      pdone      = 1'b0;
      rec_a      = '0;
      rec_b      = '0;

      if (req_accept) begin
         if (req_kind == KIND_RESTART) begin
            phase_in  = PH_IDLE;
            tag_in    = 8'd0;
            fbc_in    = 4'd0;
            text_in   = 16'd0;
            acc1_in   = 32'd0;
            acc2_in   = 32'd0;
            slots_in  = 16'd0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  lay = tag_layout(req_pool_byte);
                  if (more_slots) begin
                     if (!lay.known) begin
                        halted_in                = 1'b1;
                        push_cnt                 = 2'd1;
                        push_rec[0].slot_index   = slots_ff;
                        push_rec[0].entry_tag    = req_pool_byte;
                        push_rec[0].bad_tag      = 1'b1;
                     end else begin
                        tag_in   = req_pool_byte;
                        acc1_in  = 32'd0;
                        acc2_in  = 32'd0;
                        fbc_in   = 4'd0;
                        text_in  = 16'd0;
                        phase_in = PH_FIELDS;
                     end
                  end
               end
               PH_FIELDS: begin
                  if (fbc_ff < {1'b0, lay.f1_len}) begin
                     acc1_in = {acc1_ff[23:0], req_pool_byte};
                  end else begin
                     acc2_in = {acc2_ff[23:0], req_pool_byte};
                  end
                  fbc_in = fbc_ff + 4'd1;
                  if (fbc_in >= ({1'b0, lay.f1_len} + {1'b0, lay.f2_len})) begin
                     if (tag_ff == TAG_UTF8 && acc1_in != 32'd0) begin
                        text_in  = acc1_in[15:0];
                        phase_in = PH_TEXT;
                     end else begin
                        finish = 1'b1;
                     end
                  end
               end
               PH_TEXT: begin
                  push_cnt                 = 2'd1;
                  push_rec[0].slot_index   = slots_ff;
                  push_rec[0].entry_tag    = tag_ff;
                  push_rec[0].first_value  = acc1_ff;
                  push_rec[0].text_byte    = req_pool_byte;
                  push_rec[0].is_text_byte = 1'b1;
                  text_in = text_ff - 16'd1;
                  if (text_in == 16'd0) begin
                     finish     = 1'b1;
                     text_first = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // entry finished: one record, or two for Long/Double
      if (finish) begin
         wide     = (tag_ff == TAG_LONG) || (tag_ff == TAG_DOUBLE);
         slots_in = slots_ff + (wide ? 16'd2 : 16'd1);
         pdone    = ({1'b0, slots_in} + 17'd1) >= {1'b0, pool_count_ff};
         phase_in = PH_IDLE;
         fbc_in   = 4'd0;
         text_in  = 16'd0;

         rec_a.slot_index   = slots_ff;
         rec_a.entry_tag    = tag_ff;
         rec_a.first_value  = acc1_in;
         rec_a.second_value = acc2_in;
         rec_a.entry_done   = 1'b1;
         rec_a.pool_done    = wide ? 1'b0 : pdone;
         rec_b              = rec_a;
         rec_b.slot_index   = slots_ff + 16'd1;
         rec_b.pool_done    = pdone;

         if (text_first) begin
            push_rec[1] = rec_a;
            push_cnt    = 2'd2;
         end else begin
            push_rec[0] = rec_a;
            push_rec[1] = rec_b;
            push_cnt    = wide ? 2'd2 : 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tag_ff    <= 8'd0;
         fbc_ff    <= 4'd0;
         text_ff   <= 16'd0;
         acc1_ff   <= 32'd0;
         acc2_ff   <= 32'd0;
         slots_ff  <= 16'd0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         fbc_ff    <= fbc_in;
         text_ff   <= text_in;
         acc1_ff   <= acc1_in;
         acc2_ff   <= acc2_in;
         slots_ff  <= slots_in;
         halted_ff <= halted_in;
      end
   end

   //---------------------------------------------------------------------
   // result queue and output fields
   //---------------------------------------------------------------------
   ccpp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_rec  (push_rec),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_rec   (head_rec)
   );

   assign rsp_slot_index   = head_rec.slot_index;
   assign rsp_entry_tag    = head_rec.entry_tag;
   assign rsp_first_value  = head_rec.first_value;
   assign rsp_second_value = head_rec.second_value;
   assign rsp_text_byte    = head_rec.text_byte;
   assign rsp_is_text_byte = head_rec.is_text_byte;
   assign rsp_entry_done   = head_rec.entry_done;
   assign rsp_bad_tag      = head_rec.bad_tag;
   assign rsp_pool_done    = head_rec.pool_done;

   //---------------------------------------------------------------------
   // assertions
   //---------------------------------------------------------------------
   // a restart leaves the parser idle at slot zero
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_kind == KIND_RESTART |=>
         phase_ff == PH_IDLE && slots_ff == 16'd0 && !halted_ff)
      else $error("restart did not clear parse state");

   // once halted, only a restart produces activity; no records are queued
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> push_cnt == 2'd0)
      else $error("results produced while halted");

   // the input side is only held off while results are waiting
   a_stall_has_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty result queue");

   // pool completion only ever rides on an entry record
   a_pool_done_on_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pool_done |-> rsp_entry_done && !rsp_is_text_byte && !rsp_bad_tag)
      else $error("pool_done on a non-record result");

endmodule

FILE: tb/class_constant_pool_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_constant_pool_parser_tb
// Self-checking bench for the constant pool byte-stream parser.
// ----------------------------------------------------------------------------
// A short table of directed transactions covers the count extremes, the
// unknown tag, the restart, the empty and the long Utf8 and a wide entry on
// the last slot. A randomized part then streams well-formed entries with
// random contents, mixed with unknown tags, entries cut short by restarts and
// bytes sent after the pool is done. Each accepted request runs through a
// parser model kept in the bench; its records are queued and compared field
// by field with every accepted result. Sender gaps and receiver stalls change
// from phase to phase, and pool_count is rewritten between phases.
// ----------------------------------------------------------------------------
module class_constant_pool_parser_tb;
   import ccpp_pkg::*;

   localparam logic [1:0] CSR_POOL_COUNT = 2'd0;   // pool_count register address
   localparam int DRAIN_CYCLES = 12;              // result queue plus pipeline
   localparam int SEGMENTS = 8;
   localparam int SEG_ITEMS = 106;

   typedef enum logic [1:0] {
      CHK_MODEL,   // expectation comes from the parser model
      CHK_NONE,    // no result may follow
      CHK_ONE      // exactly the record typed in the row
   } row_check_type;

   typedef struct {
      bit            is_csr;
      logic          kind;
      logic [15:0]   data;     // pool byte, or the pool_count value
      row_check_type chk;
      rsp_rec_type   want;
   } stim_row_type;

   // ---------------------------------------------------------------- DUT I/O
   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_BYTE;
   logic [7:0]  req_pool_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_slot_index;
   logic [7:0]  rsp_entry_tag;
   logic [31:0] rsp_first_value;
   logic [31:0] rsp_second_value;
   logic [7:0]  rsp_text_byte;
   logic        rsp_is_text_byte;
   logic        rsp_entry_done;
   logic        rsp_bad_tag;
   logic        rsp_pool_done;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = CSR_POOL_COUNT;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   class_constant_pool_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_pool_byte    (req_pool_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_entry_tag    (rsp_entry_tag),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_is_text_byte (rsp_is_text_byte),
      .rsp_entry_done   (rsp_entry_done),
      .rsp_bad_tag      (rsp_bad_tag),
      .rsp_pool_done    (rsp_pool_done),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // ------------------------------------------------------- parser model state
   logic [15:0]     pool_count_reg = 16'd0;
   parse_phase_type phase = PH_IDLE;
   logic [7:0]      cur_tag = 8'd0;
   logic [3:0]      field_bytes = 4'd0;
   logic [15:0]     text_left = 16'd0;
   logic [31:0]     acc_first = 32'd0;
   logic [31:0]     acc_second = 32'd0;
   logic [15:0]     slots_filled = 16'd0;
   bit              halted = 1'b0;

   rsp_rec_type  step_recs[$];      // records caused by the latest byte
   rsp_rec_type  expected_recs[$];  // records still owed by the DUT
   rsp_rec_type  got;
   stim_row_type directed_rows[$];

   int fails = 0;
   int useful_items = 0;            // requests that changed parser state
   int sender_idle_pct = 0;
   int recv_stall_pct = 0;

   // ------------------------------------------------------------------ clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------ model
   // field byte counts per tag; returns 0 for a tag the parser rejects
   function automatic bit tag_fields(input logic [7:0] tag, output int f1, output int f2);
      f1 = 0;
      f2 = 0;
      case (tag)
         TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: f1 = 2;
         TAG_INTEGER, TAG_FLOAT: f1 = 4;
         TAG_LONG, TAG_DOUBLE: begin
            f1 = 4;
            f2 = 4;
         end
         TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAME_TYPE,
         TAG_INVOKE_DYN: begin
            f1 = 2;
            f2 = 2;
         end
         TAG_METHOD_HNDL: begin
            f1 = 1;
            f2 = 2;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic rsp_rec_type make_rec(input logic [15:0] slot, input logic [7:0] tag,
                                            input logic [31:0] v1, input logic [31:0] v2,
                                            input logic [7:0] tb, input logic is_tb,
                                            input logic done, input logic bad,
                                            input logic pdone);
      rsp_rec_type r;
      r.slot_index   = slot;
      r.entry_tag    = tag;
      r.first_value  = v1;
      r.second_value = v2;
      r.text_byte    = tb;
      r.is_text_byte = is_tb;
      r.entry_done   = done;
      r.bad_tag      = bad;
      r.pool_done    = pdone;
      return r;
   endfunction

   // 32-bit compare so that count 0 and slot 0xFFFF behave
   function automatic bit pool_exhausted();
      return int'(slots_filled) + 1 >= int'(pool_count_reg);
   endfunction

   // entry complete: one record, or two for the wide tags
   task automatic close_entry();
      logic [15:0] slot;
      bit          wide;
      bit          pdone;
      slot = slots_filled;
      wide = (cur_tag == TAG_LONG) || (cur_tag == TAG_DOUBLE);
      slots_filled = slots_filled + (wide ? 16'd2 : 16'd1);
      pdone = pool_exhausted();
      if (wide) begin
         step_recs = {step_recs, make_rec(slot, cur_tag, acc_first, acc_second, 8'd0, 1'b0,
                                          1'b1, 1'b0, 1'b0)};
         step_recs = {step_recs, make_rec(slot + 16'd1, cur_tag, acc_first, acc_second,
                                          8'd0, 1'b0, 1'b1, 1'b0, pdone)};
      end else begin
         step_recs = {step_recs, make_rec(slot, cur_tag, acc_first, acc_second, 8'd0, 1'b0,
                                          1'b1, 1'b0, pdone)};
      end
      phase = PH_IDLE;
      field_bytes = 4'd0;
      text_left = 16'd0;
   endtask

   // advance the model by one request; took is 0 when the byte is dropped
   task automatic parse_step(input logic kind, input logic [7:0] b, output bit took);
      int f1, f2;
      bit known;
      step_recs.delete();
      took = 1'b1;
      if (kind == KIND_RESTART) begin
         phase = PH_IDLE;
         cur_tag = 8'd0;
         field_bytes = 4'd0;
         text_left = 16'd0;
         acc_first = 32'd0;
         acc_second = 32'd0;
         slots_filled = 16'd0;
         halted = 1'b0;
         return;
      end
      if (halted) begin
         took = 1'b0;
         return;
      end
      case (phase)
         PH_IDLE: begin
            if (pool_exhausted()) begin
               took = 1'b0;
               return;
            end
            known = tag_fields(b, f1, f2);
            if (!known) begin
               halted = 1'b1;
               step_recs = {step_recs, make_rec(slots_filled, b, 32'd0, 32'd0, 8'd0, 1'b0,
                                                1'b0, 1'b1, 1'b0)};
               return;
            end
            cur_tag = b;
            acc_first = 32'd0;
            acc_second = 32'd0;
            field_bytes = 4'd0;
            text_left = 16'd0;
            phase = PH_FIELDS;
         end
         PH_FIELDS: begin
            known = tag_fields(cur_tag, f1, f2);
            if (int'(field_bytes) < f1) acc_first = {acc_first[23:0], b};
            else acc_second = {acc_second[23:0], b};
            field_bytes = field_bytes + 4'd1;
            if (int'(field_bytes) == f1 + f2) begin
               // a non-empty Utf8 goes on to its text; everything else is done
               if (cur_tag == TAG_UTF8 && acc_first != 32'd0) begin
                  text_left = acc_first[15:0];
                  phase = PH_TEXT;
               end else begin
                  close_entry();
               end
            end
         end
         PH_TEXT: begin
            step_recs = {step_recs, make_rec(slots_filled, cur_tag, acc_first, 32'd0, b,
                                             1'b1, 1'b0, 1'b0, 1'b0)};
            text_left = text_left - 16'd1;
            if (text_left == 16'd0) close_entry();
         end
         default: phase = PH_IDLE;
      endcase
   endtask

   // --------------------------------------------------------------- checking
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         fails++;
      end
   endfunction

   // result monitor; the receiver stall is redrawn every cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_recs.size() == 0) begin
            $error("result transaction with no record expected (slot %0h tag %0h)",
                   rsp_slot_index, rsp_entry_tag);
            fails++;
         end else begin
            got = expected_recs.pop_front();
            check_field("slot_index", 32'(got.slot_index), 32'(rsp_slot_index));
            check_field("entry_tag", 32'(got.entry_tag), 32'(rsp_entry_tag));
            check_field("first_value", got.first_value, rsp_first_value);
            check_field("second_value", got.second_value, rsp_second_value);
            check_field("text_byte", 32'(got.text_byte), 32'(rsp_text_byte));
            check_field("is_text_byte", 32'(got.is_text_byte), 32'(rsp_is_text_byte));
            check_field("entry_done", 32'(got.entry_done), 32'(rsp_entry_done));
            check_field("bad_tag", 32'(got.bad_tag), 32'(rsp_bad_tag));
            check_field("pool_done", 32'(got.pool_done), 32'(rsp_pool_done));
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // ---------------------------------------------------------------- driving
   // one request transaction: hold it until taken, then maybe leave a gap
   task automatic send_item(input logic kind, input logic [7:0] b, input row_check_type chk,
                            input rsp_rec_type want);
      bit took;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_pool_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      parse_step(kind, b, took);
      if (took) useful_items++;
      case (chk)
         CHK_MODEL: foreach (step_recs[i]) expected_recs = {expected_recs, step_recs[i]};
         CHK_ONE:   expected_recs = {expected_recs, want};
         default:   ;
      endcase
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(KIND_BYTE, b, CHK_MODEL, '0);
   endtask

   task automatic send_restart();
      send_item(KIND_RESTART, 8'($urandom_range(255)), CHK_MODEL, '0);
   endtask

   // wait until every owed record is back and the block has settled
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_recs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write of pool_count, then a read back
   task automatic write_pool_count(input logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_POOL_COUNT;
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      pool_count_reg = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      check_field("pool_count", {16'd0, value}, {16'd0, csr_prdata[15:0]});
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ------------------------------------------------------------- generators
   function automatic logic [7:0] pick_known_tag();
      case ($urandom_range(13))
         0:  return TAG_UTF8;
         1:  return TAG_INTEGER;
         2:  return TAG_FLOAT;
         3:  return TAG_LONG;
         4:  return TAG_DOUBLE;
         5:  return TAG_CLASS;
         6:  return TAG_STRING;
         7:  return TAG_FIELDREF;
         8:  return TAG_METHODREF;
         9:  return TAG_IMETHODREF;
         10: return TAG_NAME_TYPE;
         11: return TAG_METHOD_HNDL;
         12: return TAG_METHOD_TYPE;
         default: return TAG_INVOKE_DYN;
      endcase
   endfunction

   function automatic logic [7:0] pick_unknown_tag();
      logic [7:0] b;
      int f1, f2;
      do b = 8'($urandom_range(255)); while (tag_fields(b, f1, f2));
      return b;
   endfunction

   // one well-formed entry; with cut set a restart breaks in somewhere
   task automatic send_entry(input logic [7:0] tag, input bit cut);
      int f1, f2, n, stop;
      logic [15:0] len;
      logic [7:0] b;
      void'(tag_fields(tag, f1, f2));
      len = 16'd0;
      if (tag == TAG_UTF8) begin
         // mostly short strings, now and then a longer one
         len = ($urandom_range(9) == 0) ? 16'($urandom_range(7, 40))
                                        : 16'($urandom_range(0, 5));
      end
      n = f1 + f2 + int'(len);
      stop = cut ? $urandom_range(0, n - 1) : n;
      send_byte(tag);
      for (int k = 0; k < n; k++) begin
         if (k == stop) begin
            send_restart();
            return;
         end
         if (tag == TAG_UTF8 && k == 0) b = len[15:8];
         else if (tag == TAG_UTF8 && k == 1) b = len[7:0];
         else b = 8'($urandom_range(255));
         send_byte(b);
      end
   endtask

   // one random phase with its own count and idling mode
   task automatic run_segment(input int seg);
      logic [15:0] count;
      int target, start, r;
      case (seg % 4)
         0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
         default: begin sender_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case (seg)
         0: count = 16'd2;
         3: count = 16'hFFFF;
         5: count = 16'd1;
         default: count = 16'($urandom_range(3, 48));
      endcase
      target = (count < 16'd2) ? 12 : SEG_ITEMS;
      wait_drained();
      write_pool_count(count);
      // half the time the new count lands mid-pool
      if ($urandom_range(1) == 0) send_restart();
      start = useful_items;
      while (useful_items - start < target) begin
         if (halted || (phase == PH_IDLE && pool_exhausted())) begin
            // stray bytes that must be dropped, then start over
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(255)));
            send_restart();
         end else begin
            r = $urandom_range(99);
            if (r < 86) send_entry(pick_known_tag(), 1'b0);
            else if (r < 91) send_byte(pick_unknown_tag());
            else if (r < 96) send_entry(pick_known_tag(), 1'b1);
            else send_restart();
         end
      end
   endtask

   // ---------------------------------------------------------- directed rows
   function automatic void add_req(input logic kind, input logic [7:0] b,
                                   input row_check_type chk, input rsp_rec_type want);
      stim_row_type row;
      row.is_csr = 1'b0;
      row.kind = kind;
      row.data = {8'd0, b};
      row.chk = chk;
      row.want = want;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void add_csr(input logic [15:0] value);
      stim_row_type row;
      row.is_csr = 1'b1;
      row.kind = KIND_BYTE;
      row.data = value;
      row.chk = CHK_NONE;
      row.want = '0;
      directed_rows = {directed_rows, row};
   endfunction

   function automatic void build_directed();
      // count 0 after reset and count 1: nothing to parse
      add_req(KIND_BYTE, TAG_CLASS, CHK_NONE, '0);
      add_csr(16'd1);
      add_req(KIND_BYTE, TAG_CLASS, CHK_NONE, '0);
      // count 3: unknown tag zero halts, the next byte is dropped
      add_csr(16'd3);
      add_req(KIND_BYTE, 8'h00, CHK_ONE,
              make_rec(16'd0, 8'h00, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0));
      add_req(KIND_BYTE, TAG_UTF8, CHK_NONE, '0);
      add_req(KIND_RESTART, 8'hFF, CHK_NONE, '0);
      // empty Utf8 closes on its second length byte
      add_req(KIND_BYTE, TAG_UTF8, CHK_NONE, '0);
      add_req(KIND_BYTE, 8'h00, CHK_NONE, '0);
      add_req(KIND_BYTE, 8'h00, CHK_ONE,
              make_rec(16'd0, TAG_UTF8, 32'd0, 32'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0));
      // Double on the last slot: both records, pool done on the second
      add_req(KIND_BYTE, TAG_DOUBLE, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'h7F, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'hFF, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'hFF, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'hFF, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'h80, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'h00, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'h00, CHK_MODEL, '0);
      add_req(KIND_BYTE, 8'h01, CHK_MODEL, '0);
      // past the end of the pool the tag is dropped
      add_req(KIND_BYTE, TAG_METHODREF, CHK_NONE, '0);
      // full-scale count, Utf8 of maximum length cut short by a restart
      add_csr(16'hFFFF);
      add_req(KIND_RESTART, 8'h00, CHK_NONE, '0);
      add_req(KIND_BYTE, TAG_UTF8, CHK_NONE, '0);
      add_req(KIND_BYTE, 8'hFF, CHK_NONE, '0);
      add_req(KIND_BYTE, 8'hFF, CHK_NONE, '0);
      add_req(KIND_BYTE, 8'hC3, CHK_ONE,
              make_rec(16'd0, TAG_UTF8, 32'h0000_FFFF, 32'd0, 8'hC3, 1'b1, 1'b0, 1'b0, 1'b0));
      add_req(KIND_RESTART, 8'h5A, CHK_NONE, '0);
   endfunction

   // ------------------------------------------------------------------- main
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_directed();
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_drained();
            write_pool_count(directed_rows[i].data);
         end else begin
            send_item(directed_rows[i].kind, directed_rows[i].data[7:0],
                      directed_rows[i].chk, directed_rows[i].want);
         end
      end

      for (int seg = 0; seg < SEGMENTS; seg++) run_segment(seg);

      sender_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      if (expected_recs.size() != 0) begin
         $error("%0d expected records never arrived", expected_recs.size());
         fails++;
      end
      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ccpp_pkg.sv
rtl/ccpp_rsp_queue.sv
rtl/class_constant_pool_parser.sv
tb/class_constant_pool_parser_tb.sv
